// File: rtl/rational_sigmoid_approx_unit_assert.svh
// assertion macros shared by the checker files of the sigmoid unit
// no dependencies; include by bare file name
`ifndef RATIONAL_SIGMOID_APPROX_UNIT_ASSERT_SVH
`define RATIONAL_SIGMOID_APPROX_UNIT_ASSERT_SVH

// clocked property, masked while reset is high
`define RSA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// clocked property that must also hold across reset
`define RSA_ASSERT_NORST(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/rsa_pkg.sv
// shared types and constants of the rational sigmoid unit
// no dependencies
package rsa_pkg;

   // quotient of the curve term is below 2^14
   localparam int QUO_W    = 14;
   localparam int ACT_W    = 16;
   localparam int REGION_W = 2;

   localparam logic [REGION_W-1:0] REGION_LOW   = 2'd0;
   localparam logic [REGION_W-1:0] REGION_CURVE = 2'd1;
   localparam logic [REGION_W-1:0] REGION_HIGH  = 2'd2;

   localparam logic [ACT_W-1:0] ACT_ZERO = 16'd0;
   localparam logic [ACT_W-1:0] ACT_HALF = 16'd16384;
   localparam logic [ACT_W-1:0] ACT_FULL = 16'd32768;

   // side information carried along the divider
   typedef struct packed {
      logic                neg;
      logic [REGION_W-1:0] region;
   } side_type;

endpackage

// File: rtl/rsa_prep.sv
// front stages: sign split, gain multiply, clamp test, dividend and divisor
// depends on rsa_pkg
module rsa_prep #(
   parameter int DATA_WIDTH = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic [DATA_WIDTH-1:0]   in_net,
   input  logic [DATA_WIDTH-1:0]   gain,
   output logic                    in_ready,
   input  logic                    out_adv,
   output logic                    out_valid,
   output rsa_pkg::side_type       out_side,
   output logic [DATA_WIDTH+19:0]  out_num,
   output logic [DATA_WIDTH+5:0]   out_den
);
   import rsa_pkg::*;

   localparam int W   = DATA_WIDTH;
   localparam int MW  = 2 * W - 1;     // product magnitude width
   localparam int CW  = MW + 2;        // room for 3 * product
   localparam int TW  = W + 3;         // product width inside the curve region
   localparam int NW  = W + 20;
   localparam int DW  = W + 6;
   localparam logic [CW-1:0] CLAMP_LIM = CW'(20) << W;

   // stage 1: sign and magnitude of both operands
   logic           v1_ff;
   logic           neg1_ff, neg1_in;
   logic [W-1:0]   mag_a1_ff, mag_a1_in;
   logic [W-1:0]   mag_b1_ff, mag_b1_in;
   // stage 2: product magnitude
   logic           v2_ff;
   logic           neg2_ff;
   logic [MW-1:0]  prod2_ff, prod2_in;
   logic [2*W-1:0] prod_full;
   // stage 3: clamp decision
   logic           v3_ff;
   side_type       side3_ff, side3_in;
   logic [TW-1:0]  mt3_ff, mt3_in;
   logic [CW-1:0]  triple;
   // stage 4: dividend and divisor
   logic           v4_ff;
   side_type       side4_ff;
   logic [NW-1:0]  num4_ff, num4_in;
   logic [DW-1:0]  den4_ff, den4_in;
   logic [W+7:0]   m23;
   logic [DW-1:0]  den_base;

   logic en1, en2, en3, en4;

   // stage enables, a stage moves when empty or when its successor moves
   assign en4      = !v4_ff || out_adv;
   assign en3      = !v3_ff || en4;
   assign en2      = !v2_ff || en3;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1;

   // sign split
   always_comb begin
      neg1_in   = in_net[W-1] ^ gain[W-1];
      mag_a1_in = in_net[W-1] ? (~in_net + W'(1)) : in_net;
      mag_b1_in = gain[W-1]   ? (~gain + W'(1))   : gain;
   end

   // magnitude product, at most 2^(2W-2)
   assign prod_full = mag_a1_ff * mag_b1_ff;
   assign prod2_in  = prod_full[MW-1:0];

   // clamp test: 3*M against 20 * 2^W
   always_comb begin
      triple = {2'b00, prod2_ff} + {1'b0, prod2_ff, 1'b0};
      side3_in.neg = neg2_ff;
      if (triple >= CLAMP_LIM) begin
         side3_in.region = neg2_ff ? REGION_LOW : REGION_HIGH;
      end else begin
         side3_in.region = REGION_CURVE;
      end
      mt3_in = prod2_ff[TW-1:0];
   end

   // dividend 94208*M = 23*M*2^12, divisor 5*(2^W + M)
   always_comb begin
      m23 = ({5'b0, mt3_ff} << 4) + ({5'b0, mt3_ff} << 2) + ({5'b0, mt3_ff} << 1)
          + {5'b0, mt3_ff};
      num4_in  = {m23, 12'b0};
      den_base = DW'(mt3_ff) + (DW'(1) << W);
      den4_in  = (den_base << 2) + den_base;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= in_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (en1) begin
         neg1_ff   <= neg1_in;
         mag_a1_ff <= mag_a1_in;
         mag_b1_ff <= mag_b1_in;
      end
      if (en2) begin
         neg2_ff  <= neg1_ff;
         prod2_ff <= prod2_in;
      end
      if (en3) begin
         side3_ff <= side3_in;
         mt3_ff   <= mt3_in;
      end
      if (en4) begin
         side4_ff <= side3_ff;
         num4_ff  <= num4_in;
         den4_ff  <= den4_in;
      end
   end

   assign out_valid = v4_ff;
   assign out_side  = side4_ff;
   assign out_num   = num4_ff;
   assign out_den   = den4_ff;

endmodule

// File: rtl/rsa_div_step.sv
// one registered restoring division step, settles one quotient bit
// depends on rsa_pkg
module rsa_div_step #(
   parameter int NUM_W = 36,
   parameter int DEN_W = 22,
   parameter int SHIFT = 0
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  rsa_pkg::side_type          in_side,
   input  logic [NUM_W-1:0]           in_rem,
   input  logic [DEN_W-1:0]           in_den,
   input  logic [rsa_pkg::QUO_W-1:0]  in_quo,
   output logic                       in_ready,
   input  logic                       out_adv,
   output logic                       out_valid,
   output rsa_pkg::side_type          out_side,
   output logic [NUM_W-1:0]           out_rem,
   output logic [DEN_W-1:0]           out_den,
   output logic [rsa_pkg::QUO_W-1:0]  out_quo
);
   import rsa_pkg::*;

   logic             valid_ff;
   side_type         side_ff;
   logic [NUM_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [NUM_W-1:0] den_sh;
   logic             take;
   logic             en;

   assign en       = !valid_ff || out_adv;
   assign in_ready = en;

   // compare against the shifted divisor and subtract when it fits
   always_comb begin
      den_sh        = NUM_W'(in_den) << SHIFT;
      take          = (in_rem >= den_sh);
      rem_in        = take ? (in_rem - den_sh) : in_rem;
      quo_in        = in_quo;
      quo_in[SHIFT] = take;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff <= in_side;
         rem_ff  <= rem_in;
         den_ff  <= in_den;
         quo_ff  <= quo_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_side  = side_ff;
   assign out_rem   = rem_ff;
   assign out_den   = den_ff;
   assign out_quo   = quo_ff;

endmodule

// File: rtl/rational_sigmoid_approx_unit.sv
// top level of the rational sigmoid unit: gain register, pipeline, output stage
// depends on rsa_pkg, rsa_prep and rsa_div_step
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | req_net_input
//   rsp     | out       | rsp_valid/rsp_stall | rsp_activation, rsp_region
//   csr     | in        | csr_valid/csr_ready | csr_gain
//
// one transaction enters per cycle while req_stall is low; the pipe has four front
// stages (sign, multiply, clamp, dividend/divisor), fourteen divider stages of one
// quotient bit each, and the output register.
// every stage holds its item while the next one is full and stalled; bubbles
// are squeezed out, so req_stall only rises when the whole pipe is backed up.
// synchronous reset clears all valid bits and loads the gain with 1.0.
module rational_sigmoid_approx_unit #(
   parameter int DATA_WIDTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [DATA_WIDTH-1:0]      req_net_input,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [rsa_pkg::ACT_W-1:0]  rsp_activation,
   output logic [rsa_pkg::REGION_W-1:0] rsp_region,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [DATA_WIDTH-1:0]      csr_gain
);
   import rsa_pkg::*;

   localparam int NW = DATA_WIDTH + 20;
   localparam int DW = DATA_WIDTH + 6;

   logic [DATA_WIDTH-1:0] gain_ff;

   logic             prep_ready;
   logic             stg_valid [QUO_W+1];
   side_type         stg_side  [QUO_W+1];
   logic [NW-1:0]    stg_rem   [QUO_W+1];
   logic [DW-1:0]    stg_den   [QUO_W+1];
   logic [QUO_W-1:0] stg_quo   [QUO_W+1];
   logic             stg_ready [QUO_W+1];

   logic             out_en;
   logic             rsp_valid_ff;
   logic [ACT_W-1:0] act_ff, act_in;
   logic [REGION_W-1:0] region_ff;

   // gain register, always ready
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= DATA_WIDTH'(256);
      end else if (csr_valid) begin
         gain_ff <= csr_gain;
      end
   end

   // front stages
   rsa_prep #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_net    (req_net_input),
      .gain      (gain_ff),
      .in_ready  (prep_ready),
      .out_adv   (stg_ready[0]),
      .out_valid (stg_valid[0]),
      .out_side  (stg_side[0]),
      .out_num   (stg_rem[0]),
      .out_den   (stg_den[0])
   );
   assign req_stall  = !prep_ready;
   assign stg_quo[0] = '0;

   // divider stages, most significant quotient bit first
   for (genvar k = 0; k < QUO_W; k++) begin : g_div
      rsa_div_step #(
         .NUM_W (NW),
         .DEN_W (DW),
         .SHIFT (QUO_W - 1 - k)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stg_valid[k]),
         .in_side   (stg_side[k]),
         .in_rem    (stg_rem[k]),
         .in_den    (stg_den[k]),
         .in_quo    (stg_quo[k]),
         .in_ready  (stg_ready[k]),
         .out_adv   (stg_ready[k+1]),
         .out_valid (stg_valid[k+1]),
         .out_side  (stg_side[k+1]),
         .out_rem   (stg_rem[k+1]),
         .out_den   (stg_den[k+1]),
         .out_quo   (stg_quo[k+1])
      );
   end

   // output register
   assign out_en           = !rsp_valid_ff || !rsp_stall;
   assign stg_ready[QUO_W] = out_en;

   always_comb begin
      case (stg_side[QUO_W].region)
         REGION_LOW:  act_in = ACT_ZERO;
         REGION_HIGH: act_in = ACT_FULL;
         default: begin
            if (stg_side[QUO_W].neg) begin
               act_in = ACT_HALF - ACT_W'(stg_quo[QUO_W]);
            end else begin
               act_in = ACT_HALF + ACT_W'(stg_quo[QUO_W]);
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_en) begin
         rsp_valid_ff <= stg_valid[QUO_W];
      end
   end

   always_ff @(posedge clock) begin
      if (out_en) begin
         act_ff    <= act_in;
         region_ff <= stg_side[QUO_W].region;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_activation = act_ff;
   assign rsp_region     = region_ff;

endmodule

// File: rtl/rsa_checker.sv
// port-level checks of the sigmoid unit, bound to the top level
// depends on rsa_pkg and rational_sigmoid_approx_unit_assert.svh
`include "rational_sigmoid_approx_unit_assert.svh"

module rsa_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [rsa_pkg::ACT_W-1:0]    rsp_activation,
   input logic [rsa_pkg::REGION_W-1:0] rsp_region
);
   import rsa_pkg::*;

   logic                        rsp_wait;
   logic [ACT_W+REGION_W-1:0]   rsp_word;
   logic                        region_ok;

   assign rsp_wait = rsp_valid && rsp_stall;
   assign rsp_word = {rsp_activation, rsp_region};

   // clamp regions give the exact end values, the curve stays strictly inside
   assign region_ok = (rsp_region == REGION_LOW && rsp_activation == ACT_ZERO)
                   || (rsp_region == REGION_HIGH && rsp_activation == ACT_FULL)
                   || (rsp_region == REGION_CURVE && rsp_activation != ACT_ZERO
                       && rsp_activation < ACT_FULL);

   // result channel keeps a stalled transaction
   `RSA_ASSERT(a_rsp_hold, clock, reset, rsp_wait |=> rsp_valid, "rsp_valid dropped")
   `RSA_ASSERT(a_rsp_stable, clock, reset, rsp_wait |=> $stable(rsp_word), "rsp payload moved")

   `RSA_ASSERT(a_region_value, clock, reset, rsp_valid |-> region_ok, "bad activation")

   // reset empties the pipeline
   `RSA_ASSERT_NORST(a_reset_empty, clock, reset |=> !rsp_valid, "valid after reset")

endmodule

bind rational_sigmoid_approx_unit rsa_checker u_rsa_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_activation (rsp_activation),
   .rsp_region     (rsp_region)
);

// File: tb/rational_sigmoid_approx_unit_test.sv
// self-checking testbench of the rational sigmoid unit: directed and random net inputs
// under several gain settings, with random gaps and stalls on both channels
// depends on rsa_pkg and rational_sigmoid_approx_unit
`timescale 1ns / 100ps

module rational_sigmoid_approx_unit_test;
   import rsa_pkg::*;

   localparam int DATA_WIDTH = 16;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 40;

   // curve constants: 753664 / 40 is 0.575 in Q1.15
   localparam logic [63:0] CURVE_NUM = 64'd753664;
   localparam logic [63:0] CURVE_DEN = 64'd40;
   localparam logic [63:0] UNITY = 64'd1 << DATA_WIDTH;
   // |x| >= 20/3 means 3 * M >= 20 * 2^F
   localparam logic [63:0] CLAMP_LIMIT = 64'd20 * UNITY;
   localparam logic [DATA_WIDTH-1:0] GAIN_RESET = DATA_WIDTH'(256);

   typedef logic [DATA_WIDTH-1:0] fixed_word_type;

   typedef struct packed {
      logic [ACT_W-1:0]    activation;
      logic [REGION_W-1:0] region;
   } sigmoid_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   fixed_word_type        req_net_input = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [ACT_W-1:0]      rsp_activation;
   logic [REGION_W-1:0]   rsp_region;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   fixed_word_type        csr_gain = '0;

   sigmoid_result_type expected_activations[$];
   fixed_word_type     gain_setting = GAIN_RESET;
   int unsigned        idle_pct = 0;
   int unsigned        stall_pct = 0;
   int unsigned        stall_hold = 0;
   int unsigned        error_count = 0;
   int unsigned        cycle_count = 0;

   rational_sigmoid_approx_unit #(
      .DATA_WIDTH(DATA_WIDTH)
   ) DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_net_input (req_net_input),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_activation(rsp_activation),
      .rsp_region    (rsp_region),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_gain      (csr_gain)
   );

   always #5 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("rational_sigmoid_approx_unit_test: done, errors");
         $finish;
      end
   end

   // softsign sigmoid of net * gain, exact product, truncated quotient
   function automatic sigmoid_result_type predict_sigmoid(input fixed_word_type net,
                                                          input fixed_word_type lambda);
      logic [63:0]        net_mag;
      logic [63:0]        gain_mag;
      logic [63:0]        prod_mag;
      logic [63:0]        quo;
      logic               negative;
      sigmoid_result_type res;
      net_mag  = net[DATA_WIDTH-1] ? UNITY - 64'(net) : 64'(net);
      gain_mag = lambda[DATA_WIDTH-1] ? UNITY - 64'(lambda) : 64'(lambda);
      prod_mag = net_mag * gain_mag;
      negative = (net[DATA_WIDTH-1] != lambda[DATA_WIDTH-1]) && (prod_mag != 0);
      if (3 * prod_mag >= CLAMP_LIMIT) begin
         res.activation = negative ? ACT_ZERO : ACT_FULL;
         res.region     = negative ? REGION_LOW : REGION_HIGH;
      end else begin
         quo = (CURVE_NUM * prod_mag) / (CURVE_DEN * (UNITY + prod_mag));
         res.activation = negative ? ACT_HALF - quo[ACT_W-1:0] : ACT_HALF + quo[ACT_W-1:0];
         res.region     = REGION_CURVE;
      end
      return res;
   endfunction

   // result check first, then record new transactions and gain writes
   always @(posedge clock) begin
      sigmoid_result_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_activations.size() == 0) begin
               $error("unexpected result: activation %0d region %0d",
                      rsp_activation, rsp_region);
               error_count++;
            end else begin
               want = expected_activations.pop_front();
               if (rsp_activation !== want.activation) begin
                  $error("activation: expected %0d, got %0d",
                         want.activation, rsp_activation);
                  error_count++;
               end
               if (rsp_region !== want.region) begin
                  $error("region: expected %0d, got %0d", want.region, rsp_region);
                  error_count++;
               end
            end
         end
         if (req_valid && !req_stall)
            expected_activations = {expected_activations,
                                    predict_sigmoid(req_net_input, gain_setting)};
         if (csr_valid && csr_ready)
            gain_setting = csr_gain;
      end
   end

   // receiver back-pressure, occasionally held for a long stretch
   always @(posedge clock) begin
      if (stall_hold != 0) begin
         stall_hold <= stall_hold - 1;
         rsp_stall  <= 1'b1;
      end else if ($urandom_range(99) < stall_pct) begin
         stall_hold <= ($urandom_range(9) == 0) ? $urandom_range(25, 5) : 0;
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   function automatic int unsigned pick_gap();
      if ($urandom_range(99) >= idle_pct)
         return 0;
      if ($urandom_range(9) == 0)
         return $urandom_range(30, 8);
      return $urandom_range(3, 1);
   endfunction

   // mix of full-range and small net inputs so the curve is hit often
   function automatic fixed_word_type random_net();
      fixed_word_type mag;
      case ($urandom_range(3))
         0, 1: return fixed_word_type'($urandom);
         2: mag = fixed_word_type'($urandom_range(2047));
         default: mag = fixed_word_type'($urandom_range(127));
      endcase
      return $urandom_range(1) ? -mag : mag;
   endfunction

   function automatic fixed_word_type random_gain();
      fixed_word_type mag;
      if ($urandom_range(1))
         return fixed_word_type'($urandom);
      mag = fixed_word_type'($urandom_range(1023));
      return $urandom_range(1) ? -mag : mag;
   endfunction

   // one transaction on the input channel, then an optional gap
   task automatic send_net(input fixed_word_type net);
      int unsigned gap;
      req_valid     <= 1'b1;
      req_net_input <= net;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // waits first until the last accepted transaction is recorded, then until the queue is empty
   task automatic wait_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_activations.size() != 0)
         @(posedge clock);
   endtask

   // gain write, only issued with the pipe empty
   task automatic write_gain(input fixed_word_type lambda);
      csr_valid <= 1'b1;
      csr_gain  <= lambda;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic run_random(input int unsigned count, input int unsigned idle,
                             input int unsigned stall);
      idle_pct  = idle;
      stall_pct = stall;
      repeat (count) send_net(random_net());
      wait_drain();
   endtask

   // reset gain of 1.0: extremes, zero, and both sides of each breakpoint
   task automatic test_reset_gain();
      idle_pct  = 30;
      stall_pct = 30;
      send_net('0);
      send_net(16'sd1);
      send_net(-16'sd1);
      send_net(16'h7FFF);
      send_net(16'h8000);
      send_net(16'sd1706);
      send_net(16'sd1707);
      send_net(-16'sd1706);
      send_net(-16'sd1707);
      wait_drain();
   endtask

   // zero, largest, most negative, negative unity and smallest gains
   task automatic test_gain_extremes();
      idle_pct  = 30;
      stall_pct = 30;
      write_gain('0);
      send_net(16'h7FFF);
      send_net(16'h8000);
      wait_drain();
      // breakpoint between 13 and 14 at the largest gain
      write_gain(16'h7FFF);
      send_net(16'sd13);
      send_net(16'sd14);
      send_net(-16'sd13);
      send_net(-16'sd14);
      wait_drain();
      write_gain(16'h8000);
      send_net(16'sd1);
      send_net(16'h7FFF);
      send_net(16'h8000);
      wait_drain();
      // negative gain mirrors the curve
      write_gain(-16'sd256);
      send_net(16'sd1706);
      send_net(-16'sd1707);
      wait_drain();
      write_gain(16'sd1);
      send_net(16'h7FFF);
      send_net(16'h8000);
      wait_drain();
   endtask

   // random streams across gain settings, with and without idling
   task automatic test_random_stream();
      write_gain(GAIN_RESET);
      run_random(100, 20, 20);
      write_gain(random_gain());
      run_random(60, 0, 0);
      write_gain(random_gain());
      run_random(80, 40, 40);
      write_gain(16'h8000);
      run_random(40, 10, 50);
      write_gain(16'h7FFF);
      run_random(40, 50, 10);
      write_gain(16'sd1);
      run_random(40, 0, 0);
      write_gain(random_gain());
      run_random(40, 60, 60);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_reset_gain();
      test_gain_extremes();
      test_random_stream();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("rational_sigmoid_approx_unit_test: done, clean");
      else
         $display("rational_sigmoid_approx_unit_test: done, errors");
      $finish;
   end

endmodule
